### sv/ncmc_pkg.sv
// Shared types, constants and narrow divide helpers for the nixie clock mode controller.
// No dependencies; imported by every module of the block.
package ncmc_pkg;

	localparam int NUM_DIGITS = 6;

	localparam logic [1:0] MODE_CLOCK  = 2'd0;
	localparam logic [1:0] MODE_DATE   = 2'd1;
	localparam logic [1:0] MODE_TEMP   = 2'd2;
	localparam logic [1:0] MODE_SWATCH = 2'd3;

	localparam logic [15:0] TIMEOUT_RESET = 16'd10000;
	localparam logic [7:0]  CODE_BLANK    = 8'd11;

	localparam int SEP_LO_BIT = 30;
	localparam int SEP_HI_BIT = 62;

	// reciprocal constants for the stopwatch split
	localparam logic [28:0] RECIP_1000 = 29'h10624DD3;
	localparam int          SHIFT_1000 = 38;
	localparam logic [22:0] RECIP_60   = 23'd4473925;
	localparam int          SHIFT_60   = 28;
	localparam logic [17:0] INV_1875   = 18'd251099;
	localparam logic [18:0] MAX_Q1875  = 19'd279;

	typedef logic [7:0] digit_t;
	typedef digit_t [NUM_DIGITS-1:0] digits_t;

	typedef struct packed {
		logic [2:0]        button_levels;
		logic [31:0]       now_ms;
		logic [4:0]        hour;
		logic [5:0]        minute;
		logic [5:0]        second;
		logic [3:0]        month;
		logic [4:0]        day_of_month;
		logic [6:0]        year_two_digit;
		logic signed [7:0] temp_whole;
		logic [6:0]        temp_frac;
	} item_t;

	typedef struct packed {
		digits_t     digits;
		logic        sep;
		logic        set_time;
		logic [4:0]  new_hour;
		logic [5:0]  new_minute;
		logic [1:0]  mode_now;
		logic        sw;
	} disp_t;

	typedef struct packed {
		logic [7:0] minutes;
		logic [5:0] seconds;
		logic [6:0] centis;
	} sw_count_t;

	function automatic logic [6:0] div10(input logic [9:0] x);
		logic [17:0] p;
		p = 18'(x) * 18'd205;
		return p[17:11];
	endfunction

	function automatic logic [3:0] mod10(input logic [9:0] x);
		logic [6:0] q;
		logic [9:0] r;
		q = div10(x);
		r = x - ({3'd0, q} << 3) - ({3'd0, q} << 1);
		return r[3:0];
	endfunction

endpackage

### sv/ncmc_ctrl.sv
// Mode sequencing, clock/date/temperature digit formation, roll animation and stopwatch control.
// Holds all per-transaction state; depends on ncmc_pkg.
module ncmc_ctrl import ncmc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  item_t       item,
	input  logic [15:0] timeout_ms,
	output disp_t       disp,
	output logic [31:0] el
);

	logic [1:0]  mode_q, mode_d, mode_a;
	logic [1:0]  prev_mode_q;
	logic [2:0]  held_q;
	logic [31:0] entry_q, entry_d;
	logic        sep_q, sep_d;
	logic [3:0]  last_sec_q, last_sec_d;
	logic [3:0]  last_min_q, last_min_d;
	logic [NUM_DIGITS-1:0][3:0] roll_q, rd_a, rd_n;
	logic [2:0]  roll_pos_q, rp_a, rp_n;
	logic [1:0]  roll_rep_q, rep_n, rep_inc;
	logic        sw_run_q, sw_run_d;
	logic [31:0] sw_start_q, sw_start_d;
	logic [31:0] sw_el_q, sw_el_d, sw_el_now;
	logic        sw_clr_q, sw_clr_d;

	logic        press_mode, right, left;
	logic        roll_restart, hit, sw_zero;
	logic [2:0]  k;
	digit_t      sel_d;
	logic [3:0]  sel_r;
	logic [18:0] sw_chk;
	digits_t     d_clk, d_roll, d_date, d_temp;
	logic [6:0]  min_inc;
	logic [5:0]  hr_inc, min_next;
	logic [4:0]  hr_next;
	logic [7:0]  t_abs, t_q, t_r, tq8, tr8;
	logic        t_neg;

	assign press_mode = item.button_levels[0] & ~held_q[0];
	assign right      = item.button_levels[1] & ~held_q[1];
	assign left       = item.button_levels[2] & ~held_q[2];

	assign d_clk[0] = 8'(div10(10'(item.hour)));
	assign d_clk[1] = 8'(mod10(10'(item.hour)));
	assign d_clk[2] = 8'(div10(10'(item.minute)));
	assign d_clk[3] = 8'(mod10(10'(item.minute)));
	assign d_clk[4] = 8'(div10(10'(item.second)));
	assign d_clk[5] = 8'(mod10(10'(item.second)));

	assign d_date[0] = 8'(div10(10'(item.month)));
	assign d_date[1] = 8'(mod10(10'(item.month)));
	assign d_date[2] = 8'(div10(10'(item.day_of_month)));
	assign d_date[3] = 8'(mod10(10'(item.day_of_month)));
	assign d_date[4] = 8'(mod10(10'(div10(10'(item.year_two_digit)))));
	assign d_date[5] = 8'(mod10(10'(item.year_two_digit)));

	assign t_neg = item.temp_whole[7];
	assign t_abs = t_neg ? (8'd0 - $unsigned(item.temp_whole)) : $unsigned(item.temp_whole);
	assign tq8   = 8'(div10(10'(t_abs)));
	assign tr8   = 8'(mod10(10'(t_abs)));
	assign t_q   = t_neg ? (8'd0 - tq8) : tq8;
	assign t_r   = t_neg ? (8'd0 - tr8) : tr8;

	assign d_temp[0] = CODE_BLANK;
	assign d_temp[1] = CODE_BLANK;
	assign d_temp[2] = t_q;
	assign d_temp[3] = t_r;
	assign d_temp[4] = 8'(div10(10'(item.temp_frac)));
	assign d_temp[5] = 8'(mod10(10'(item.temp_frac)));

	assign min_inc  = 7'(item.minute) + 7'd1;
	assign min_next = (min_inc >= 7'd60) ? 6'(min_inc - 7'd60) : 6'(min_inc);
	assign hr_inc   = 6'(item.hour) + 6'd1;
	assign hr_next  = (hr_inc >= 6'd24) ? 5'(hr_inc - 6'd24) : 5'(hr_inc);

	assign sw_chk  = 19'(sw_el_q[31:13] * INV_1875);
	assign sw_zero = sw_clr_q || ((sw_el_q[12:0] == 13'd0) && (sw_chk <= MAX_Q1875));
	assign sw_el_now = item.now_ms - sw_start_q;

	always_comb begin
		mode_a = mode_q + 2'(press_mode);

		roll_restart = (last_min_q != d_clk[3][3:0]) && (roll_pos_q == 3'd0);
		rp_a = roll_restart ? 3'(NUM_DIGITS) : roll_pos_q;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			rd_a[i] = roll_restart ? 4'(i + 1) : roll_q[i];
		end
		k = rp_a - 3'd1;
		sel_d = '0;
		sel_r = '0;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (3'(i) == k) begin
				sel_d = d_clk[i];
				sel_r = rd_a[i];
			end
		end
		hit = (rp_a != 3'd0) && (sel_d == {4'd0, sel_r});
		rep_inc = roll_rep_q + 2'd1;
		rp_n = rp_a;
		rep_n = roll_rep_q;
		if (hit) begin
			if (rep_inc == 2'd2) begin
				rp_n = rp_a - 3'd1;
				rep_n = 2'd0;
			end else begin
				rep_n = rep_inc;
			end
		end
		d_roll = d_clk;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			rd_n[i] = rd_a[i];
			if (3'(i) < rp_n) begin
				d_roll[i] = {4'd0, rd_a[i]};
				rd_n[i] = (rd_a[i] == 4'd9) ? 4'd0 : rd_a[i] + 4'd1;
			end
		end

		mode_d     = mode_a;
		entry_d    = entry_q;
		sep_d      = sep_q;
		last_sec_d = last_sec_q;
		last_min_d = last_min_q;
		sw_run_d   = sw_run_q;
		sw_start_d = sw_start_q;
		sw_el_d    = sw_el_q;
		sw_clr_d   = sw_clr_q;
		el         = sw_el_q;

		disp.digits     = d_roll;
		disp.sep        = sep_q;
		disp.set_time   = 1'b0;
		disp.new_hour   = '0;
		disp.new_minute = '0;
		disp.mode_now   = mode_a;
		disp.sw         = 1'b0;

		unique case (mode_a) inside
			MODE_CLOCK: begin
				if (right || left) begin
					disp.set_time   = 1'b1;
					disp.new_minute = right ? min_next : item.minute;
					disp.new_hour   = left ? hr_next : item.hour;
				end
				if (last_sec_q != d_clk[5][3:0])
					sep_d = ~sep_q;
				last_sec_d = d_roll[5][3:0];
				last_min_d = d_roll[3][3:0];
			end
			MODE_DATE, MODE_TEMP: begin
				entry_d = (prev_mode_q != mode_a) ? item.now_ms : entry_q;
				if ((item.now_ms - entry_d) > 32'(timeout_ms))
					mode_d = MODE_CLOCK;
				if (mode_a == MODE_DATE) begin
					sep_d = 1'b1;
					disp.digits = d_date;
				end else begin
					sep_d = 1'b0;
					disp.digits = d_temp;
				end
			end
			default: begin
				disp.sw = 1'b1;
				sep_d = 1'b1;
				if (sw_run_q) begin
					sw_el_d  = sw_el_now;
					sw_clr_d = 1'b0;
					el       = sw_el_now;
					if (left)
						sw_run_d = 1'b0;
				end else begin
					if (left) begin
						if (sw_zero)
							sw_start_d = item.now_ms;
						sw_run_d = 1'b1;
					end
					if (right)
						sw_clr_d = 1'b1;
					el = (right || sw_clr_q) ? 32'd0 : sw_el_q;
				end
			end
		endcase
		disp.sep = sep_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_CLOCK;
			prev_mode_q <= MODE_CLOCK;
			held_q      <= '0;
			entry_q     <= '0;
			sep_q       <= 1'b0;
			last_sec_q  <= '0;
			last_min_q  <= '0;
			for (int i = 0; i < NUM_DIGITS; i++) begin
				roll_q[i] <= 4'(i + 1);
			end
			roll_pos_q  <= 3'(NUM_DIGITS);
			roll_rep_q  <= '0;
			sw_run_q    <= 1'b0;
			sw_start_q  <= '0;
			sw_el_q     <= '0;
			sw_clr_q    <= 1'b1;
		end else if (adv) begin
			mode_q      <= mode_d;
			prev_mode_q <= mode_d;
			held_q      <= item.button_levels;
			entry_q     <= entry_d;
			sep_q       <= sep_d;
			last_sec_q  <= last_sec_d;
			last_min_q  <= last_min_d;
			sw_run_q    <= sw_run_d;
			sw_start_q  <= sw_start_d;
			sw_el_q     <= sw_el_d;
			sw_clr_q    <= sw_clr_d;
			if (mode_a == MODE_CLOCK) begin
				roll_q     <= rd_n;
				roll_pos_q <= rp_n;
				roll_rep_q <= rep_n;
			end
		end
	end

endmodule

### sv/ncmc_swdiv.sv
// Stopwatch split: elapsed milliseconds into minutes, seconds and hundredths over three stages.
// Reciprocal multiplies only; depends on ncmc_pkg.
module ncmc_swdiv import ncmc_pkg::*; (
	input  logic        clk,
	input  logic        ld3,
	input  logic        ld4,
	input  logic        ld5,
	input  logic [31:0] el,
	output sw_count_t   cnt
);

	logic [60:0] p1000;
	logic [22:0] q_s3;
	logic [9:0]  ms_lo_s3;
	logic [45:0] p60;
	logic [9:0]  ms_sub;
	logic [9:0]  millis_s4;
	logic [7:0]  q60_s4;
	logic [5:0]  qlo_s4;
	sw_count_t   cnt_s5;

	assign p1000  = {29'd0, el} * {32'd0, RECIP_1000};
	assign p60    = {23'd0, q_s3} * {23'd0, RECIP_60};
	assign ms_sub = 10'(q_s3[9:0] * 10'd1000);

	always_ff @(posedge clk) begin
		if (ld3) begin
			q_s3     <= p1000[SHIFT_1000+22:SHIFT_1000];
			ms_lo_s3 <= el[9:0];
		end
		if (ld4) begin
			millis_s4 <= ms_lo_s3 - ms_sub;
			q60_s4    <= p60[SHIFT_60+7:SHIFT_60];
			qlo_s4    <= q_s3[5:0];
		end
		if (ld5) begin
			cnt_s5.minutes <= q60_s4;
			cnt_s5.seconds <= qlo_s4 - 6'(q60_s4[5:0] * 6'd60);
			cnt_s5.centis  <= div10(millis_s4);
		end
	end

	assign cnt = cnt_s5;

endmodule

### sv/ncmc_disp.sv
// Final digit selection, one-hot tube encoding and the result register.
// Depends on ncmc_pkg.
module ncmc_disp import ncmc_pkg::*; (
	input  logic        clk,
	input  logic        ld,
	input  disp_t       side,
	input  sw_count_t   cnt,
	output logic [63:0] tube_pattern,
	output logic        set_time,
	output logic [4:0]  new_hour,
	output logic [5:0]  new_minute,
	output logic [1:0]  mode_now
);

	digits_t     dig;
	logic [63:0] pat;
	logic [5:0]  b;
	logic [63:0] tube_q;
	logic        set_q;
	logic [4:0]  hour_q;
	logic [5:0]  minute_q;
	logic [1:0]  mode_q;

	always_comb begin
		if (side.sw) begin
			dig[0] = 8'(div10(10'(cnt.minutes)));
			dig[1] = 8'(mod10(10'(cnt.minutes)));
			dig[2] = 8'(div10(10'(cnt.seconds)));
			dig[3] = 8'(mod10(10'(cnt.seconds)));
			dig[4] = 8'(div10(10'(cnt.centis)));
			dig[5] = 8'(mod10(10'(cnt.centis)));
		end else begin
			dig = side.digits;
		end
	end

	always_comb begin
		pat = '0;
		b = '0;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (dig[i] < 8'd10) begin
				if (i >= 3)
					b = (dig[i] == 8'd0) ? 6'(i * 10 + 11) : 6'(i * 10) + dig[i][5:0] + 6'd1;
				else
					b = (dig[i] == 8'd0) ? 6'(i * 10 + 9) : 6'(i * 10) + dig[i][5:0] - 6'd1;
				pat[b] = 1'b1;
			end
		end
		if (side.sep) begin
			pat[SEP_LO_BIT] = 1'b1;
			pat[SEP_HI_BIT] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			tube_q   <= pat;
			set_q    <= side.set_time;
			hour_q   <= side.new_hour;
			minute_q <= side.new_minute;
			mode_q   <= side.mode_now;
		end
	end

	assign tube_pattern = tube_q;
	assign set_time     = set_q;
	assign new_hour     = hour_q;
	assign new_minute   = minute_q;
	assign mode_now     = mode_q;

endmodule

### sv/nixie_clock_mode_controller_core.sv
// Top level of the nixie clock mode controller: input register, control stage, stopwatch
// divider stages and result register. Depends on ncmc_pkg, ncmc_ctrl, ncmc_swdiv, ncmc_disp.
//
// One tick transaction is taken every clock cycle while in_ready is high; its result passes
// through the input register, control stage, three stopwatch divider stages and result
// register. The depth is set by the reciprocal-multiply split of the stopwatch's elapsed
// milliseconds. Each stage holds its item while the one ahead is full, so the block keeps
// accepting as long as a bubble remains anywhere in the pipeline.
module nixie_clock_mode_controller_core import ncmc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        button_levels,
	input  logic [31:0]       now_ms,
	input  logic [4:0]        hour,
	input  logic [5:0]        minute,
	input  logic [5:0]        second,
	input  logic [3:0]        month,
	input  logic [4:0]        day_of_month,
	input  logic [6:0]        year_two_digit,
	input  logic signed [7:0] temp_whole,
	input  logic [6:0]        temp_frac,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [63:0]       tube_pattern,
	output logic              set_time,
	output logic [4:0]        new_hour,
	output logic [5:0]        new_minute,
	output logic [1:0]        mode_now,
	input  logic              cfg_wr_en,
	input  logic [15:0]       cfg_wr_data
);

	logic [15:0] timeout_q;
	logic        v_s1, v_s2, v_s3, v_s4, v_s5, out_valid_q;
	logic        free1, free2, free3, free4, free5, free_o;
	item_t       item_in, item_s1;
	disp_t       disp_c, disp_s2, disp_s3, disp_s4, disp_s5;
	logic [31:0] el_c, el_s2;
	sw_count_t   cnt;

	assign item_in = '{
		button_levels:  button_levels,
		now_ms:         now_ms,
		hour:           hour,
		minute:         minute,
		second:         second,
		month:          month,
		day_of_month:   day_of_month,
		year_two_digit: year_two_digit,
		temp_whole:     temp_whole,
		temp_frac:      temp_frac
	};

	assign free_o = !out_valid_q || out_ready;
	assign free5  = !v_s5 || free_o;
	assign free4  = !v_s4 || free5;
	assign free3  = !v_s3 || free4;
	assign free2  = !v_s2 || free3;
	assign free1  = !v_s1 || free2;

	assign in_ready  = free1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= TIMEOUT_RESET;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en)
				timeout_q <= cfg_wr_data;
			if (free1)
				v_s1 <= in_valid;
			if (free2)
				v_s2 <= v_s1;
			if (free3)
				v_s3 <= v_s2;
			if (free4)
				v_s4 <= v_s3;
			if (free5)
				v_s5 <= v_s4;
			if (free_o)
				out_valid_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (free1)
			item_s1 <= item_in;
		if (free2) begin
			disp_s2 <= disp_c;
			el_s2   <= el_c;
		end
		if (free3)
			disp_s3 <= disp_s2;
		if (free4)
			disp_s4 <= disp_s3;
		if (free5)
			disp_s5 <= disp_s4;
	end

	ncmc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (v_s1 && free2),
		.item       (item_s1),
		.timeout_ms (timeout_q),
		.disp       (disp_c),
		.el         (el_c)
	);

	ncmc_swdiv u_swdiv (
		.clk (clk),
		.ld3 (free3),
		.ld4 (free4),
		.ld5 (free5),
		.el  (el_s2),
		.cnt (cnt)
	);

	ncmc_disp u_disp (
		.clk          (clk),
		.ld           (free_o),
		.side         (disp_s5),
		.cnt          (cnt),
		.tube_pattern (tube_pattern),
		.set_time     (set_time),
		.new_hour     (new_hour),
		.new_minute   (new_minute),
		.mode_now     (mode_now)
	);

endmodule

### sv/ncmc_checker.sv
// Port-level checks for the nixie clock mode controller, bound to the top level.
// Depends on ncmc_pkg and nixie_clock_mode_controller_core.
module ncmc_checker import ncmc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] tube_pattern,
	input logic        set_time,
	input logic [4:0]  new_hour,
	input logic [5:0]  new_minute,
	input logic [1:0]  mode_now
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tube_pattern) && $stable(mode_now)
			&& $stable(set_time) && $stable(new_hour) && $stable(new_minute))
		else $error("result transaction changed while stalled");

	a_sep_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> tube_pattern[SEP_LO_BIT] == tube_pattern[SEP_HI_BIT])
		else $error("separator bits differ");

	a_set_clock: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && set_time |-> mode_now == MODE_CLOCK)
		else $error("time write outside clock mode");

	a_set_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !set_time |-> new_hour == 5'd0 && new_minute == 6'd0)
		else $error("new time not zero without a write");

	a_mode_sep: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_now != MODE_CLOCK
			|-> tube_pattern[SEP_LO_BIT] == (mode_now != MODE_TEMP))
		else $error("separator wrong for mode");

endmodule

bind nixie_clock_mode_controller_core ncmc_checker u_ncmc_checker (.*);
